// ===== hw/rtl/ngz_pkg.sv =====
// Package: record type, sentence kinds, character codes and conversion helpers.
`default_nettype none
package ngz_pkg;

    localparam int FRAC_DIGITS = 4;
    localparam int FRAC_KEEP   = (FRAC_DIGITS < 4) ? FRAC_DIGITS : 4;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_ZDA   = 2'd2
    } kind_t;

    localparam logic [1:0] HEMI_UNKNOWN = 2'd0;
    localparam logic [1:0] HEMI_POS     = 2'd1;
    localparam logic [1:0] HEMI_NEG     = 2'd2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_Z      = 8'h5A;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [16:0] lat_dm;
        logic [13:0] lat_fr;
        logic [1:0]  ns;
        logic [16:0] lon_dm;
        logic [13:0] lon_fr;
        logic [1:0]  ew;
        logic [15:0] alt;
        logic [15:0] geo;
        logic [6:0]  sats;
        logic        fix;
        logic        date_ok;
    } rec_t;

    // Five BCD digits to binary with constant weights.
    function automatic logic [16:0] bcd_to_bin(input logic [19:0] b);
        logic [16:0] s;
        s = 17'(b[19:16]) * 17'd10000 + 17'(b[15:12]) * 17'd1000
          + 17'(b[11:8]) * 17'd100 + 17'(b[7:4]) * 17'd10 + 17'(b[3:0]);
        return s;
    endfunction

    // Scale kept fraction digits to units of 0.0001 minute.
    function automatic logic [13:0] scale_frac(input logic [13:0] f, input logic [3:0] cnt);
        logic [3:0]  n;
        logic [16:0] v;
        n = (cnt > 4'(FRAC_KEEP)) ? 4'(FRAC_KEEP) : cnt;
        case (n)
            4'd0:    v = 17'd0;
            4'd1:    v = 17'(f) * 17'd1000;
            4'd2:    v = 17'(f) * 17'd100;
            4'd3:    v = 17'(f) * 17'd10;
            default: v = 17'(f);
        endcase
        return v[13:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ngz_if.sv =====
// Channel interfaces: received byte in, parsed record out.
`default_nettype none
interface ngz_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ngz_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  sentence_kind;
    logic [16:0] utc_hms;
    logic [22:0] utc_ymd;
    logic [16:0] lat_dddmm;
    logic [13:0] lat_frac;
    logic [1:0]  north_south;
    logic [16:0] lon_dddmm;
    logic [13:0] lon_frac;
    logic [1:0]  east_west;
    logic [15:0] alt_msl;
    logic [15:0] geoid_sep;
    logic [8:0]  status_word;
    modport source (output valid, output sentence_kind, output utc_hms, output utc_ymd,
                    output lat_dddmm, output lat_frac, output north_south, output lon_dddmm,
                    output lon_frac, output east_west, output alt_msl, output geoid_sep,
                    output status_word, input ready);
    modport sink   (input valid, input sentence_kind, input utc_hms, input utc_ymd,
                    input lat_dddmm, input lat_frac, input north_south, input lon_dddmm,
                    input lon_frac, input east_west, input alt_msl, input geoid_sep,
                    input status_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/nmea_gga_zda_parser.sv =====
// A line feed taken at the input waits in the input register and, once it may advance,
// loads the output register; its record is then offered until it is taken.
// Throughput: one byte per cycle; the input register stalls only when it holds a
// line feed and the output register is full and not being taken.
// Reset: asynchronous, active low; staged and committed records clear to zero,
// hemispheres unknown, the parser waits in field 0 and both registers are empty.
`default_nettype none
module nmea_gga_zda_parser
    import ngz_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ngz_byte_if.sink  rx,
    ngz_rec_if.source rec
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    rec_t       out_rec_reg;
    logic       is_lf;
    logic       adv;
    kind_t      emit_kind;
    rec_t       emit_rec;

    assign is_lf    = (in_byte_reg == CH_LF);
    assign adv      = in_valid_reg && !(is_lf && out_valid_reg && !rec.ready);
    assign rx.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    ngz_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .chr       (in_byte_reg),
        .emit_kind (emit_kind),
        .emit_rec  (emit_rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && is_lf)
            out_valid_reg <= 1'b1;
        else if (rec.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && is_lf)
        begin
            out_kind_reg <= emit_kind;
            out_rec_reg  <= emit_rec;
        end
    end

    assign rec.valid         = out_valid_reg;
    assign rec.sentence_kind = out_kind_reg;
    assign rec.utc_hms       = {out_rec_reg.hour, out_rec_reg.minute, out_rec_reg.second};
    assign rec.utc_ymd       = {out_rec_reg.year, out_rec_reg.month, out_rec_reg.day};
    assign rec.lat_dddmm     = out_rec_reg.lat_dm;
    assign rec.lat_frac      = out_rec_reg.lat_fr;
    assign rec.north_south   = out_rec_reg.ns;
    assign rec.lon_dddmm     = out_rec_reg.lon_dm;
    assign rec.lon_frac      = out_rec_reg.lon_fr;
    assign rec.east_west     = out_rec_reg.ew;
    assign rec.alt_msl       = out_rec_reg.alt;
    assign rec.geoid_sep     = out_rec_reg.geo;
    assign rec.status_word   = {out_rec_reg.date_ok, out_rec_reg.fix, out_rec_reg.sats};

endmodule
`default_nettype wire

// ===== hw/rtl/ngz_core.sv =====
// Parser state: field tracking, staged and committed records, one byte per step.
`default_nettype none
module ngz_core
    import ngz_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] chr,
    output kind_t           emit_kind,
    output rec_t            emit_rec
);

    logic [3:0]  fld_reg, fld_next;
    logic [3:0]  pos_reg, pos_next;
    logic        pt_reg, pt_next;
    kind_t       id_reg, id_next;
    logic [19:0] bcd_reg, bcd_next;
    logic [15:0] hacc_reg, hacc_next;
    logic [13:0] frac_reg, frac_next;
    rec_t        stg_reg, stg_next;
    rec_t        com_reg, com_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_reg  <= '0;
            pos_reg  <= '0;
            pt_reg   <= 1'b0;
            id_reg   <= KIND_OTHER;
            bcd_reg  <= '0;
            hacc_reg <= '0;
            frac_reg <= '0;
            stg_reg  <= '0;
            com_reg  <= '0;
        end
        else if (step)
        begin
            fld_reg  <= fld_next;
            pos_reg  <= pos_next;
            pt_reg   <= pt_next;
            id_reg   <= id_next;
            bcd_reg  <= bcd_next;
            hacc_reg <= hacc_next;
            frac_reg <= frac_next;
            stg_reg  <= stg_next;
            com_reg  <= com_next;
        end
    end

    always_comb
    begin
        logic [3:0]  d;
        logic [3:0]  pos_inc;
        logic        nonempty;
        logic [6:0]  t7;
        logic [13:0] t14;
        logic [19:0] t20;
        d = (chr >= CH_ZERO && chr <= CH_NINE) ? 4'(chr - CH_ZERO) : 4'd0;
        pos_inc = (pos_reg < 4'd15) ? pos_reg + 4'd1 : pos_reg;
        nonempty = pt_reg || (pos_reg != 4'd0);
        t7 = '0;
        t14 = '0;
        t20 = '0;

        fld_next  = fld_reg;
        pos_next  = pos_reg;
        pt_next   = pt_reg;
        id_next   = id_reg;
        bcd_next  = bcd_reg;
        hacc_next = hacc_reg;
        frac_next = frac_reg;
        stg_next  = stg_reg;
        com_next  = com_reg;
        emit_kind = KIND_OTHER;

        if (chr == CH_DOLLAR)
        begin
            stg_next  = com_reg;
            fld_next  = '0;
            pos_next  = 4'd1;
            pt_next   = 1'b0;
            id_next   = KIND_OTHER;
            bcd_next  = '0;
            hacc_next = '0;
            frac_next = '0;
        end
        else if (chr == CH_COMMA || chr == CH_LF)
        begin
            // Close the current field.
            if (fld_reg == 4'd0 && pos_reg < 4'd6)
                id_next = KIND_OTHER;
            if (nonempty && id_next == KIND_GGA)
            begin
                case (fld_reg)
                    4'd2:
                    begin
                        stg_next.lat_dm = bcd_to_bin(bcd_reg);
                        stg_next.lat_fr = scale_frac(frac_reg, pos_reg);
                    end
                    4'd4:
                    begin
                        stg_next.lon_dm = bcd_to_bin(bcd_reg);
                        stg_next.lon_fr = scale_frac(frac_reg, pos_reg);
                    end
                    4'd9:    stg_next.alt = hacc_reg;
                    4'd11:   stg_next.geo = hacc_reg;
                    default: ;
                endcase
            end
            fld_next  = (fld_reg < 4'd15) ? fld_reg + 4'd1 : fld_reg;
            pos_next  = '0;
            pt_next   = 1'b0;
            bcd_next  = '0;
            hacc_next = '0;
            frac_next = '0;
            if (chr == CH_LF)
            begin
                emit_kind = id_next;
                if (id_next == KIND_ZDA)
                    stg_next.date_ok = 1'b1;
                if (id_next != KIND_OTHER)
                    com_next = stg_next;
                stg_next = com_next;
                fld_next = '0;
                id_next  = KIND_OTHER;
            end
        end
        else
        begin
            pos_next = pos_inc;
            if (fld_reg == 4'd0)
            begin
                if (pos_reg == 4'd3)
                    id_next = (chr == CH_G) ? KIND_GGA : (chr == CH_Z) ? KIND_ZDA : KIND_OTHER;
                else if (pos_reg == 4'd4)
                begin
                    if ((id_reg == KIND_GGA && chr != CH_G) ||
                        (id_reg == KIND_ZDA && chr != CH_D))
                        id_next = KIND_OTHER;
                end
                else if (pos_reg == 4'd5)
                begin
                    if (chr != CH_A)
                        id_next = KIND_OTHER;
                end
            end
            else if (id_reg != KIND_OTHER && fld_reg == 4'd1)
            begin
                t7 = 7'(stg_reg.hour) * 7'd10 + 7'(d);
                case (pos_reg)
                    4'd0:
                    begin
                        stg_next.hour   = 5'(d);
                        stg_next.minute = '0;
                        stg_next.second = '0;
                    end
                    4'd1: stg_next.hour = (t7 > 7'd31) ? 5'd31 : t7[4:0];
                    4'd2: stg_next.minute = 6'(d);
                    4'd3:
                    begin
                        t7 = 7'(stg_reg.minute) * 7'd10 + 7'(d);
                        stg_next.minute = (t7 > 7'd63) ? 6'd63 : t7[5:0];
                    end
                    4'd4: stg_next.second = 6'(d);
                    4'd5:
                    begin
                        t7 = 7'(stg_reg.second) * 7'd10 + 7'(d);
                        stg_next.second = (t7 > 7'd63) ? 6'd63 : t7[5:0];
                    end
                    default: ;
                endcase
            end
            else if (id_reg == KIND_GGA)
            begin
                case (fld_reg)
                    4'd2, 4'd4:
                    begin
                        if (!pt_reg && chr == CH_POINT)
                        begin
                            pt_next  = 1'b1;
                            pos_next = '0;
                        end
                        else if (!pt_reg)
                            bcd_next = {bcd_reg[15:0], d};
                        else if (pos_reg < 4'(FRAC_KEEP))
                        begin
                            t14 = frac_reg * 14'd10 + 14'(d);
                            frac_next = t14;
                        end
                    end
                    4'd3:
                    begin
                        if (pos_reg == 4'd0 && chr == CH_N) stg_next.ns = HEMI_POS;
                        else if (pos_reg == 4'd0 && chr == CH_S) stg_next.ns = HEMI_NEG;
                    end
                    4'd5:
                    begin
                        if (pos_reg == 4'd0 && chr == CH_E) stg_next.ew = HEMI_POS;
                        else if (pos_reg == 4'd0 && chr == CH_W) stg_next.ew = HEMI_NEG;
                    end
                    4'd6:
                    begin
                        if (pos_reg == 4'd0 && chr == CH_ONE) stg_next.fix = 1'b1;
                    end
                    4'd7:
                    begin
                        if (pos_reg == 4'd0)
                            stg_next.sats = 7'(d);
                        else if (pos_reg == 4'd1)
                            stg_next.sats = stg_reg.sats * 7'd10 + 7'(d);
                    end
                    4'd9, 4'd11:
                    begin
                        t20 = 20'(hacc_reg) * 20'd10 + 20'(d);
                        if (chr == CH_POINT)
                            pt_next = 1'b1;
                        else if (!pt_reg)
                            hacc_next = (t20 > 20'd65535) ? 16'hFFFF : t20[15:0];
                    end
                    default: ;
                endcase
            end
            else if (id_reg == KIND_ZDA)
            begin
                t7 = '0;
                case (fld_reg)
                    4'd2:
                    begin
                        if (pos_reg == 4'd0)
                            stg_next.day = 5'(d);
                        else if (pos_reg == 4'd1)
                        begin
                            t7 = 7'(stg_reg.day) * 7'd10 + 7'(d);
                            stg_next.day = (t7 > 7'd31) ? 5'd31 : t7[4:0];
                        end
                    end
                    4'd3:
                    begin
                        if (pos_reg == 4'd0)
                            stg_next.month = 4'(d);
                        else if (pos_reg == 4'd1)
                        begin
                            t7 = 7'(stg_reg.month) * 7'd10 + 7'(d);
                            stg_next.month = (t7 > 7'd15) ? 4'd15 : t7[3:0];
                        end
                    end
                    4'd4:
                    begin
                        if (pos_reg == 4'd0)
                            stg_next.year = 14'(d);
                        else if (pos_reg < 4'd4)
                            stg_next.year = stg_reg.year * 14'd10 + 14'(d);
                    end
                    default: ;
                endcase
            end
        end
        emit_rec = com_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ngz_checker.sv =====
// Port-level checker for the parser, bound to the top level.
`default_nettype none
module ngz_checker
    import ngz_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  in_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  out_kind,
    input wire logic [8:0]  out_status
);

    // A held record stays offered until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("record dropped before it was taken");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_status))
        else $error("held record changed");

    // A fresh record only follows a line feed taken at the input.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_byte == CH_LF, 2))
        else $error("record without a line feed");

    // A date sentence always reports the date as valid.
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_ZDA |-> out_status[8])
        else $error("date sentence without date valid");

endmodule

bind nmea_gga_zda_parser ngz_checker u_ngz_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_byte    (rx.rx_byte),
    .out_valid  (rec.valid),
    .out_ready  (rec.ready),
    .out_kind   (rec.sentence_kind),
    .out_status (rec.status_word)
);
`default_nettype wire

// ===== dv/ngz_tb_if.sv =====
// Testbench-side note: channel interfaces come from the RTL file ngz_if.sv.
`timescale 1ns / 1ps
package ngz_tb_util;
    localparam int BURST_MAX = 12;
endpackage

// ===== dv/testbench.sv =====
// Testbench for the NMEA GGA/ZDA parser: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
module testbench;
    import ngz_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] hms;
        logic [22:0] ymd;
        logic [16:0] lat_dm;
        logic [13:0] lat_fr;
        logic [1:0]  ns;
        logic [16:0] lon_dm;
        logic [13:0] lon_fr;
        logic [1:0]  ew;
        logic [15:0] alt;
        logic [15:0] geo;
        logic [8:0]  status;
    } fix_rec_t;

    // Parser state as seen by the predictor.
    typedef struct {
        int unsigned hour, minute, second, day, month, year;
        int unsigned lat_dm, lat_fr, ns, lon_dm, lon_fr, ew, alt, geo, sats;
        bit fix, date_ok;
    } nav_t;

    logic clk;
    logic rst_n;
    ngz_byte_if rx_ch();
    ngz_rec_if  rec_ch();

    nmea_gga_zda_parser dut (.clk(clk), .rst_n(rst_n), .rx(rx_ch.sink), .rec(rec_ch.source));

    byte unsigned pending_bytes[$];
    fix_rec_t     expected_records[$];
    int           errors;
    int unsigned  cycles;
    bit           stim_done;
    bit           hold_sender;
    int           burst_left, gap_left;

    nav_t        staged, committed;
    int unsigned fld, pos, acc, facc;
    bit          in_frac;
    kind_t       id;

    function automatic int unsigned dig(byte unsigned c);
        return (c >= CH_ZERO && c <= CH_NINE) ? c - CH_ZERO : 0;
    endfunction

    function automatic int unsigned sat(int unsigned v, int unsigned m);
        return v > m ? m : v;
    endfunction

    function automatic int unsigned frac_scaled();
        int unsigned v;
        int unsigned n;
        v = facc;
        n = sat(pos, FRAC_KEEP);
        for (int i = n; i < 4; i++) v *= 10;
        return v;
    endfunction

    function automatic void restart_parse(int unsigned p);
        staged = committed;
        fld = 0;
        pos = p;
        in_frac = 0;
        id = KIND_OTHER;
        acc = 0;
        facc = 0;
    endfunction

    function automatic void take_char(byte unsigned c);
        int unsigned d;
        d = dig(c);
        if (fld == 0) begin
            if (pos == 3) id = (c == CH_G) ? KIND_GGA : (c == CH_Z) ? KIND_ZDA : KIND_OTHER;
            else if (pos == 4) begin
                if ((id == KIND_GGA && c != CH_G) || (id == KIND_ZDA && c != CH_D))
                    id = KIND_OTHER;
            end
            else if (pos == 5 && c != CH_A) id = KIND_OTHER;
        end
        else if (id != KIND_OTHER && fld == 1) begin
            case (pos)
                0: begin staged.hour = d; staged.minute = 0; staged.second = 0; end
                1: staged.hour = sat(staged.hour * 10 + d, 31);
                2: staged.minute = d;
                3: staged.minute = sat(staged.minute * 10 + d, 63);
                4: staged.second = d;
                5: staged.second = sat(staged.second * 10 + d, 63);
                default: ;
            endcase
        end
        else if (id == KIND_GGA) begin
            if (fld == 2 || fld == 4) begin
                if (!in_frac && c == CH_POINT) begin
                    in_frac = 1;
                    pos = 0;
                    return;
                end
                if (!in_frac) acc = (acc * 10 + d) % 100000;
                else if (pos < FRAC_KEEP) facc = facc * 10 + d;
            end
            else if (fld == 3 && pos == 0) begin
                if (c == CH_N) staged.ns = HEMI_POS;
                else if (c == CH_S) staged.ns = HEMI_NEG;
            end
            else if (fld == 5 && pos == 0) begin
                if (c == CH_E) staged.ew = HEMI_POS;
                else if (c == CH_W) staged.ew = HEMI_NEG;
            end
            else if (fld == 6) begin
                if (pos == 0 && c == CH_ONE) staged.fix = 1;
            end
            else if (fld == 7) begin
                if (pos == 0) staged.sats = d;
                else if (pos == 1) staged.sats = staged.sats * 10 + d;
            end
            else if (fld == 9 || fld == 11) begin
                if (c == CH_POINT) in_frac = 1;
                else if (!in_frac) acc = sat(acc * 10 + d, 65535);
            end
        end
        else if (id == KIND_ZDA) begin
            if (fld == 2) begin
                if (pos == 0) staged.day = d;
                else if (pos == 1) staged.day = sat(staged.day * 10 + d, 31);
            end
            else if (fld == 3) begin
                if (pos == 0) staged.month = d;
                else if (pos == 1) staged.month = sat(staged.month * 10 + d, 15);
            end
            else if (fld == 4) begin
                if (pos == 0) staged.year = d;
                else if (pos < 4) staged.year = staged.year * 10 + d;
            end
        end
        if (pos < 15) pos++;
    endfunction

    function automatic void close_field();
        if (fld == 0 && pos < 6) id = KIND_OTHER;
        if ((in_frac || pos != 0) && id == KIND_GGA) begin
            if (fld == 2) begin staged.lat_dm = acc; staged.lat_fr = frac_scaled(); end
            else if (fld == 4) begin staged.lon_dm = acc; staged.lon_fr = frac_scaled(); end
            else if (fld == 9) staged.alt = acc;
            else if (fld == 11) staged.geo = acc;
        end
        if (fld < 15) fld++;
        pos = 0;
        in_frac = 0;
        acc = 0;
        facc = 0;
    endfunction

    // Advances the parser by one byte and queues a record on a line feed.
    function automatic void predict_byte(byte unsigned c);
        fix_rec_t r;
        nav_t     o;
        if (c == CH_DOLLAR) restart_parse(1);
        else if (c == CH_COMMA) close_field();
        else if (c != CH_LF) take_char(c);
        else begin
            close_field();
            if (id == KIND_ZDA) staged.date_ok = 1;
            if (id != KIND_OTHER) committed = staged;
            o = committed;
            r.kind   = id;
            r.hms    = {o.hour[4:0], o.minute[5:0], o.second[5:0]};
            r.ymd    = {o.year[13:0], o.month[3:0], o.day[4:0]};
            r.lat_dm = o.lat_dm[16:0];
            r.lat_fr = o.lat_fr[13:0];
            r.ns     = o.ns[1:0];
            r.lon_dm = o.lon_dm[16:0];
            r.lon_fr = o.lon_fr[13:0];
            r.ew     = o.ew[1:0];
            r.alt    = o.alt[15:0];
            r.geo    = o.geo[15:0];
            r.status = {o.date_ok, o.fix, o.sats[6:0]};
            expected_records.push_back(r);
            restart_parse(0);
        end
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endfunction

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'(CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    // Field text: mostly digits, sometimes empty, a point or junk.
    function automatic string num_field(int ilen, int flen);
        string s;
        int    r;
        r = $urandom_range(0, 19);
        if (r == 0) return "";
        if (r == 1) return {"-", digits(ilen)};
        if (r == 2) return {digits(ilen), "x", digits(1)};
        s = digits(ilen);
        if (flen > 0 || r == 3) s = {s, ".", digits(flen)};
        return s;
    endfunction

    function automatic void gen_gga();
        string s;
        string h1, h2;
        h1 = ($urandom_range(0, 1) != 0) ? "N" : "S";
        h2 = ($urandom_range(0, 1) != 0) ? "E" : "W";
        if ($urandom_range(0, 9) == 0) h1 = "";
        if ($urandom_range(0, 9) == 0) h2 = "q";
        s = {"$GPGGA,", num_field($urandom_range(0, 7), $urandom_range(0, 3)), ",",
             num_field($urandom_range(0, 7), $urandom_range(0, 6)), ",", h1, ",",
             num_field($urandom_range(0, 7), $urandom_range(0, 6)), ",", h2, ",",
             digits(1), ",", num_field($urandom_range(0, 3), 0), ",", digits(1), ",",
             num_field($urandom_range(0, 6), 1), ",M,",
             num_field($urandom_range(0, 6), 1), ",M,,*47"};
        push_str(s);
        if ($urandom_range(0, 15) == 0) push_str(digits(3));
        else pending_bytes.push_back(CH_LF);
    endfunction

    function automatic void gen_zda();
        push_str({"$GNZDA,", num_field($urandom_range(0, 7), $urandom_range(0, 2)), ",",
                  num_field($urandom_range(0, 3), 0), ",", num_field($urandom_range(0, 3), 0),
                  ",", num_field($urandom_range(0, 5), 0), ",00,00*6A"});
        pending_bytes.push_back(CH_LF);
    endfunction

    function automatic void gen_noise();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) pending_bytes.push_back(CH_COMMA);
            else pending_bytes.push_back(byte'($urandom_range(0, 255)));
        end
        pending_bytes.push_back(CH_LF);
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        errors = 0;
        cycles = 0;
        stim_done = 0;
        hold_sender = 0;
        rst_n = 0;
        committed = '{default: 0};
        restart_parse(0);
        repeat (2) @(posedge clk);
        rst_n <= 1;
        // Directed: full GGA, extremes, saturations, empty fields, unterminated, short id.
        push_str("$GPGGA,123519.00,4807.038123,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n");
        push_str("$GPZDA,235959.00,31,12,2024,00,00*6A\n");
        push_str("$GPGGA,999999,123456789.99999,S,,W,0,99,,99999999,M,-12.5,M,,\n");
        push_str("$GPZDA,,99,99,99999\n$GP\n$GPGGA,1,2,N$GPXXX,1\n");
        push_str("\n,,,,,,,,,,,,,,,,,,,,\n$GPGGA,.,.5,q,.,E,2,7\n");
        while (pending_bytes.size() != 0 || expected_records.size() != 0) @(posedge clk);
        // Forty random sentences of GGA, ZDA or noise.
        for (int i = 0; i < 40; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gen_gga();
                5, 6, 7: gen_zda();
                default: gen_noise();
            endcase
            if (i == 20) begin
                while (pending_bytes.size() != 0) @(posedge clk);
                hold_sender = 1;
                while (expected_records.size() != 0) @(posedge clk);
                hold_sender = 0;
            end
            while (pending_bytes.size() > 64) @(posedge clk);
        end
        while (pending_bytes.size() != 0) @(posedge clk);
        stim_done = 1;
    end

    // Sender: bursts with gaps between them.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rx_ch.valid <= 0;
            rx_ch.rx_byte <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else begin
            if (rx_ch.valid && rx_ch.ready) begin
                predict_byte(rx_ch.rx_byte);
                void'(pending_bytes.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                rx_ch.valid <= 0;
            end
            else if (burst_left == 0 && !(rx_ch.valid && !rx_ch.ready)) begin
                burst_left <= $urandom_range(1, ngz_tb_util::BURST_MAX);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                rx_ch.valid <= 0;
            end
            else if (!hold_sender && pending_bytes.size() != 0) begin
                rx_ch.valid <= 1;
                rx_ch.rx_byte <= pending_bytes[0];
                if (burst_left > 0) burst_left <= burst_left - 1;
            end
            else rx_ch.valid <= 0;
        end
    end

    // Receiver: stalls on a slowly shifting duty pattern; checks each record.
    always @(posedge clk or negedge rst_n) begin
        fix_rec_t w;
        if (!rst_n) rec_ch.ready <= 0;
        else begin
            cycles <= cycles + 1;
            if (rec_ch.valid && rec_ch.ready) begin
                if (expected_records.size() == 0) report("unexpected record", 0, 0);
                else begin
                    w = expected_records.pop_front();
                    if (rec_ch.sentence_kind != w.kind)
                        report("kind", rec_ch.sentence_kind, w.kind);
                    if (rec_ch.utc_hms != w.hms) report("utc_hms", rec_ch.utc_hms, w.hms);
                    if (rec_ch.utc_ymd != w.ymd) report("utc_ymd", rec_ch.utc_ymd, w.ymd);
                    if (rec_ch.lat_dddmm != w.lat_dm)
                        report("lat_dddmm", rec_ch.lat_dddmm, w.lat_dm);
                    if (rec_ch.lat_frac != w.lat_fr)
                        report("lat_frac", rec_ch.lat_frac, w.lat_fr);
                    if (rec_ch.north_south != w.ns)
                        report("north_south", rec_ch.north_south, w.ns);
                    if (rec_ch.lon_dddmm != w.lon_dm)
                        report("lon_dddmm", rec_ch.lon_dddmm, w.lon_dm);
                    if (rec_ch.lon_frac != w.lon_fr)
                        report("lon_frac", rec_ch.lon_frac, w.lon_fr);
                    if (rec_ch.east_west != w.ew)
                        report("east_west", rec_ch.east_west, w.ew);
                    if (rec_ch.alt_msl != w.alt) report("alt_msl", rec_ch.alt_msl, w.alt);
                    if (rec_ch.geoid_sep != w.geo)
                        report("geoid_sep", rec_ch.geoid_sep, w.geo);
                    if (rec_ch.status_word != w.status)
                        report("status", rec_ch.status_word, w.status);
                end
            end
            rec_ch.ready <= ((cycles / 512) % 2 == 0) ? 1'b1 : (((cycles * 7) % 11) < 6);
        end
    end

    initial begin
        rx_ch.valid = 0;
        rx_ch.rx_byte = 0;
        rec_ch.ready = 0;
        wait (stim_done);
        while (expected_records.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_records.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        wait (cycles > 400000);
        $display("== FAIL ==");
        $finish;
    end
endmodule
